>>> src/mmas_pkg.sv
// Shared types and constants of the matrix multiply/add/subtract unit.
// Used by the interfaces' users, the controller, the datapath and the top level.
package mmas_pkg;

  localparam int VAL_W  = 32;
  localparam int PROD_W = 2 * VAL_W;
  localparam int POS_W  = 3;
  localparam int DIM_W  = 4;
  localparam int OP_W   = 2;
  localparam int CIDX_W = 3;

  typedef enum logic [1:0] {
    CMD_WR_A    = 2'd0,
    CMD_WR_B    = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [OP_W-1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2
  } op_t;

  localparam logic [CIDX_W-1:0] REG_A_ROWS    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_A_COLS    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_B_ROWS    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_B_COLS    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_OPERATION = 3'd4;

  // Store commands from the controller to the datapath.
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic clr;
  } mem_cmd_t;

  // Flags of one work beat: one term of one result element.
  typedef struct packed {
    logic valid;
    logic first;
    logic last_term;
    logic last;
    logic err;
    logic mul;
    logic sub;
  } beat_t;

endpackage

>>> src/mmas_in_if.sv
// Input channel of the matrix unit: valid/ready handshake with the item fields.
// Stand-alone; field widths follow the item format.
interface mmas_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  row;
  logic [2:0]  col;
  logic [31:0] value;

  modport source (output valid, cmd, row, col, value, input ready);
  modport sink (input valid, cmd, row, col, value, output ready);
endinterface

>>> src/mmas_out_if.sv
// Result channel of the matrix unit: valid/ready handshake with the result fields.
// Stand-alone; field widths follow the result format.
interface mmas_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_row;
  logic [2:0]  out_col;
  logic [31:0] out_value;
  logic        last;
  logic        dim_error;

  modport source (output valid, out_row, out_col, out_value, last, dim_error, input ready);
  modport sink (input valid, out_row, out_col, out_value, last, dim_error, output ready);
endinterface

>>> src/mmas_ctrl.sv
// Controller of the matrix unit: configuration registers, item decode and the
// sequencer that issues one beat per term. Depends on mmas_pkg.
module mmas_ctrl
  import mmas_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic              cfg_write,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  input  logic              adv,
  output mem_cmd_t          mem_cmd,
  output beat_t             beat,
  output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] beat_i,
  output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] beat_j,
  output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] beat_k
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW = $clog2(MAX_DIM + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_ERR} state_t;

  state_t           state;
  logic [DIM_W-1:0] a_rows, a_cols, b_rows, b_cols;
  logic [OP_W-1:0]  operation;
  logic [CW-1:0]    rows, cols, depth;
  logic             mul, sub;
  logic [IW-1:0]    i, j, k;

  logic [CW-1:0] ar, ac, br, bc;
  logic          mismatch;
  logic          accept;
  logic          k_end, j_end, i_end;

  // A dimension of zero counts as one, and one beyond the store counts as its size.
  function automatic logic [CW-1:0] clamp_dim(logic [DIM_W-1:0] d);
    logic [CW-1:0] r;
    if (d == '0) begin
      r = CW'(1);
    end else if ({1'b0, d} > 5'(MAX_DIM)) begin
      r = CW'(MAX_DIM);
    end else begin
      r = CW'(d);
    end
    return r;
  endfunction

  assign ar = clamp_dim(a_rows);
  assign ac = clamp_dim(a_cols);
  assign br = clamp_dim(b_rows);
  assign bc = clamp_dim(b_cols);

  always_comb begin
    unique case (op_t'(operation))
      OP_MUL:         mismatch = (ac != br);
      OP_ADD, OP_SUB: mismatch = (ar != br) || (ac != bc);
      default:        mismatch = 1'b1;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign mem_cmd.wr_a = accept && (cmd_t'(in_cmd) == CMD_WR_A);
  assign mem_cmd.wr_b = accept && (cmd_t'(in_cmd) == CMD_WR_B);
  assign mem_cmd.clr  = accept && (cmd_t'(in_cmd) == CMD_CLEAR);

  assign k_end = (k == IW'(depth - CW'(1)));
  assign j_end = (j == IW'(cols - CW'(1)));
  assign i_end = (i == IW'(rows - CW'(1)));

  always_comb begin
    beat.valid     = (state == S_RUN) || (state == S_ERR);
    beat.first     = (state == S_ERR) || (k == '0);
    beat.last_term = (state == S_ERR) || k_end;
    beat.last      = (state == S_ERR) || (i_end && j_end);
    beat.err       = (state == S_ERR);
    beat.mul       = mul;
    beat.sub       = sub;
    beat_i         = (state == S_ERR) ? '0 : i;
    beat_j         = (state == S_ERR) ? '0 : j;
    beat_k         = (state == S_ERR) ? '0 : k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      a_rows    <= DIM_W'(8);
      a_cols    <= DIM_W'(8);
      b_rows    <= DIM_W'(8);
      b_cols    <= DIM_W'(8);
      operation <= OP_MUL;
      i         <= '0;
      j         <= '0;
      k         <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_A_ROWS:    a_rows    <= cfg_data;
          REG_A_COLS:    a_cols    <= cfg_data;
          REG_B_ROWS:    b_rows    <= cfg_data;
          REG_B_COLS:    b_cols    <= cfg_data;
          REG_OPERATION: operation <= cfg_data[OP_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (cmd_t'(in_cmd) == CMD_COMPUTE)) begin
            i     <= '0;
            j     <= '0;
            k     <= '0;
            rows  <= ar;
            cols  <= (op_t'(operation) == OP_MUL) ? bc : ac;
            depth <= (op_t'(operation) == OP_MUL) ? ac : CW'(1);
            mul   <= (op_t'(operation) == OP_MUL);
            sub   <= (op_t'(operation) == OP_SUB);
            state <= mismatch ? S_ERR : S_RUN;
          end
        end
        S_RUN: begin
          if (adv) begin
            if (!k_end) begin
              k <= k + IW'(1);
            end else begin
              k <= '0;
              if (!j_end) begin
                j <= j + IW'(1);
              end else begin
                j <= '0;
                if (i_end) begin
                  state <= S_IDLE;
                end else begin
                  i <= i + IW'(1);
                end
              end
            end
          end
        end
        S_ERR: begin
          if (adv) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/mmas_dp.sv
// Datapath of the matrix unit: element stores with valid bits, the multiply, add
// or subtract stage, the accumulator and the output register. Depends on mmas_pkg.
module mmas_dp
  import mmas_pkg::*;
#(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [2:0]        in_row,
  input  logic [2:0]        in_col,
  input  logic [VAL_W-1:0]  in_value,
  input  mem_cmd_t          mem_cmd,
  input  beat_t             beat,
  input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] beat_i,
  input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] beat_j,
  input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] beat_k,
  output logic              adv,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [POS_W-1:0]  out_row,
  output logic [POS_W-1:0]  out_col,
  output logic [VAL_W-1:0]  out_value,
  output logic              out_last,
  output logic              out_dim_error
);

  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
  localparam int ACC_W = PROD_W - FRAC_BITS + $clog2(MAX_DIM) + 1;

  logic [VAL_W-1:0] mem_a [DEPTH];
  logic [VAL_W-1:0] mem_b [DEPTH];
  logic [DEPTH-1:0] valid_a, valid_b;

  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic          in_range;

  beat_t                     s1_beat, s2_beat, s3_beat;
  beat_t                     s2_fin;
  logic [IW-1:0]             s1_i, s1_j, s2_i, s2_j, s3_i, s3_j;
  logic [VAL_W-1:0]          rd_a, rd_b;
  logic                      rd_va, rd_vb;
  logic signed [VAL_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0]  mul_res, prod;
  logic signed [ACC_W-1:0]   term, acc;
  logic                      ovf;
  logic [VAL_W-1:0]          sat_val;

  function automatic logic [AW-1:0] addr_of(int r, int c);
    return AW'(r * MAX_DIM + c);
  endfunction

  assign in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign waddr    = addr_of(int'(in_row), int'(in_col));
  // Multiply walks row i of A and column j of B; add and subtract read both at (i, j).
  assign raddr_a  = addr_of(int'(beat_i), beat.mul ? int'(beat_k) : int'(beat_j));
  assign raddr_b  = addr_of(beat.mul ? int'(beat_k) : int'(beat_i), int'(beat_j));

  // The whole pipe holds while a finished result waits at the output.
  assign adv = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (mem_cmd.wr_a && in_range) begin
      mem_a[waddr] <= in_value;
    end
    if (mem_cmd.wr_b && in_range) begin
      mem_b[waddr] <= in_value;
    end
    if (adv) begin
      rd_a <= mem_a[raddr_a];
      rd_b <= mem_b[raddr_b];
    end
  end

  // An entry never written since reset or the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= '0;
      valid_b <= '0;
    end else if (mem_cmd.clr) begin
      valid_a <= '0;
      valid_b <= '0;
    end else begin
      if (mem_cmd.wr_a && in_range) begin
        valid_a[waddr] <= 1'b1;
      end
      if (mem_cmd.wr_b && in_range) begin
        valid_b[waddr] <= 1'b1;
      end
    end
  end

  assign op_a    = rd_va ? signed'(rd_a) : '0;
  assign op_b    = rd_vb ? signed'(rd_b) : '0;
  assign mul_res = op_a * op_b;

  assign term = s2_beat.mul ? ACC_W'(prod >>> FRAC_BITS) : ACC_W'(prod);

  assign ovf     = !((&acc[ACC_W-1:VAL_W-1]) || !(|acc[ACC_W-1:VAL_W-1]));
  assign sat_val = ovf ? (acc[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}})
                       : acc[VAL_W-1:0];

  // s3 holds a finished sum only after the last term of an element.
  always_comb begin
    s2_fin       = s2_beat;
    s2_fin.valid = s2_beat.valid && s2_beat.last_term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_beat   <= '0;
      s2_beat   <= '0;
      s3_beat   <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_beat       <= beat;
      s1_i          <= beat_i;
      s1_j          <= beat_j;
      rd_va         <= valid_a[raddr_a];
      rd_vb         <= valid_b[raddr_b];

      s2_beat       <= s1_beat;
      s2_i          <= s1_i;
      s2_j          <= s1_j;
      if (s1_beat.mul) begin
        prod <= mul_res;
      end else if (s1_beat.sub) begin
        prod <= PROD_W'(op_a) - PROD_W'(op_b);
      end else begin
        prod <= PROD_W'(op_a) + PROD_W'(op_b);
      end

      s3_beat       <= s2_fin;
      s3_i          <= s2_i;
      s3_j          <= s2_j;
      if (s2_beat.valid) begin
        acc <= (s2_beat.first ? '0 : acc) + term;
      end

      out_valid <= s3_beat.valid;
      if (s3_beat.valid) begin
        out_row       <= POS_W'(s3_i);
        out_col       <= POS_W'(s3_j);
        out_value     <= s3_beat.err ? '0 : sat_val;
        out_last      <= s3_beat.last;
        out_dim_error <= s3_beat.err;
      end
    end
  end

endmodule

>>> src/matrix_mul_add_sub_unit_top.sv
// Matrix multiply/add/subtract unit: top level joining controller and datapath.
// Depends on mmas_pkg, mmas_in_if, mmas_out_if, mmas_ctrl and mmas_dp.
//
// Usage: items enter on in_ch (valid/ready). Commands write one element of
// A or B, clear both stores, or compute. A compute gives the result matrix
// on out_ch in row-major order, last set on the final element; on a
// dimension mismatch or an unused operation it gives one result with
// dim_error set. Configuration (dimensions, operation) is to be written through
// cfg_write/cfg_index/cfg_data while the unit is idle; the unit itself does not enforce this.
// A write or clear is stored as it transfers. A multiply result sums a_cols
// products, one per term, through the single shared multiply-accumulate
// unit; an add or subtract result has a single term. After its last term is
// issued, a result passes the s1, s2 and s3 registers (read, product,
// accumulate) into the output register, where it is valid on out_ch. A new
// item is taken as soon as the sequencer has issued the last term.
// Reset returns the state, configuration and pipeline valid flags to their defaults
// and marks every store entry as zero at once; no clearing pass is needed. When
// out_ch stalls, the result stays in the output register and the whole pipeline holds without loss.
module matrix_mul_add_sub_unit_top
  import mmas_pkg::*;
#(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  mmas_in_if.sink           in_ch,
  mmas_out_if.source        out_ch,
  input  logic              cfg_write,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]  cfg_data
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  mem_cmd_t      mem_cmd;
  beat_t         beat;
  logic [IW-1:0] beat_i, beat_j, beat_k;
  logic          adv;

  mmas_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adv       (adv),
    .mem_cmd   (mem_cmd),
    .beat      (beat),
    .beat_i    (beat_i),
    .beat_j    (beat_j),
    .beat_k    (beat_k)
  );

  mmas_dp #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_row        (in_ch.row),
    .in_col        (in_ch.col),
    .in_value      (in_ch.value),
    .mem_cmd       (mem_cmd),
    .beat          (beat),
    .beat_i        (beat_i),
    .beat_j        (beat_j),
    .beat_k        (beat_k),
    .adv           (adv),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_row       (out_ch.out_row),
    .out_col       (out_ch.out_col),
    .out_value     (out_ch.out_value),
    .out_last      (out_ch.last),
    .out_dim_error (out_ch.dim_error)
  );

endmodule

>>> tb/tb_matrix_mul_add_sub_unit_top.sv
// Self-checking bench for matrix_mul_add_sub_unit_top: directed and random item streams
// go through the input channel and every result element is compared with a software copy of
// the unit. Depends on mmas_pkg, mmas_in_if, mmas_out_if and the unit itself.
`timescale 1ns / 100ps

module tb_matrix_mul_add_sub_unit_top;
  import mmas_pkg::*;

  localparam int Q_FRAC        = 16;
  localparam int DIM_MAX       = 8;
  localparam int RANDOM_ITEMS  = 450;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 3_000_000;

  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [CIDX_W-1:0] REG_LAST  = 3'd7;

  typedef struct packed {
    cmd_t             cmd;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [VAL_W-1:0] value;
  } mat_item_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             last;
    logic             err;
  } elem_t;

  logic clk;
  logic rst;
  logic              cfg_write;
  logic [CIDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]  cfg_data;

  mmas_in_if  in_ch ();
  mmas_out_if out_ch ();

  matrix_mul_add_sub_unit_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Software copy of the unit: both element stores and the five registers.
  logic signed [VAL_W-1:0] mat_a [DIM_MAX][DIM_MAX];
  logic signed [VAL_W-1:0] mat_b [DIM_MAX][DIM_MAX];
  logic [DIM_W-1:0] a_rows_cfg, a_cols_cfg, b_rows_cfg, b_cols_cfg;
  logic [OP_W-1:0]  op_cfg;

  mat_item_t item_q [$];
  elem_t     result_elems [$];
  mat_item_t cur_item;
  int        send_gap;
  int        sink_stall;
  bit        idling_on;
  int        err_count = 0;
  int        cycle_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int clamp_dim(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > DIM_MAX) return DIM_MAX;
    return int'(d);
  endfunction

  function automatic logic [VAL_W-1:0] sat32(longint signed x);
    if (x > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'h8000_0000;
    return x[VAL_W-1:0];
  endfunction

  // Applies one accepted item to the copy and queues the result elements it causes.
  function automatic void eval_item(mat_item_t it);
    int ar, ac, br, bc, rows, cols;
    bit bad;
    longint signed acc, pa, pb;
    elem_t e;
    case (it.cmd)
      CMD_WR_A: mat_a[it.row][it.col] = it.value;
      CMD_WR_B: mat_b[it.row][it.col] = it.value;
      CMD_CLEAR: begin
        foreach (mat_a[i, j]) begin
          mat_a[i][j] = '0;
          mat_b[i][j] = '0;
        end
      end
      default: begin
        ar = clamp_dim(a_rows_cfg);
        ac = clamp_dim(a_cols_cfg);
        br = clamp_dim(b_rows_cfg);
        bc = clamp_dim(b_cols_cfg);
        rows = ar;
        cols = ac;
        case (op_cfg)
          OP_MUL: begin
            bad = (ac != br);
            cols = bc;
          end
          OP_ADD, OP_SUB: bad = (ar != br) || (ac != bc);
          default: bad = 1'b1;
        endcase
        if (bad) begin
          e = '{row: '0, col: '0, value: '0, last: 1'b1, err: 1'b1};
          result_elems.push_back(e);
        end else begin
          for (int i = 0; i < rows; i++) begin
            for (int j = 0; j < cols; j++) begin
              acc = 0;
              if (op_cfg == OP_MUL) begin
                for (int k = 0; k < ac; k++) begin
                  pa = mat_a[i][k];
                  pb = mat_b[k][j];
                  acc += (pa * pb) >>> Q_FRAC;
                end
              end else begin
                pa = mat_a[i][j];
                pb = mat_b[i][j];
                acc = (op_cfg == OP_ADD) ? pa + pb : pa - pb;
              end
              e.row   = i[POS_W-1:0];
              e.col   = j[POS_W-1:0];
              e.value = sat32(acc);
              e.last  = (i == rows - 1) && (j == cols - 1);
              e.err   = 1'b0;
              result_elems.push_back(e);
            end
          end
        end
      end
    endcase
  endfunction

  // Input driver: the current item is predicted on the edge where it transfers.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd   <= CMD_WR_A;
      in_ch.row   <= '0;
      in_ch.col   <= '0;
      in_ch.value <= '0;
      send_gap = 0;
      foreach (mat_a[i, j]) begin
        mat_a[i][j] = '0;
        mat_b[i][j] = '0;
      end
    end else begin
      if (in_ch.valid && in_ch.ready) eval_item(cur_item);
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (item_q.size() > 0) begin
          cur_item = item_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd   <= cur_item.cmd;
          in_ch.row   <= cur_item.row;
          in_ch.col   <= cur_item.col;
          in_ch.value <= cur_item.value;
          if (idling_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 14);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure.
  always @(posedge clk) begin
    elem_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_elems.size() == 0) begin
          $error("result transfer with nothing pending: row %0d col %0d value %h",
                 out_ch.out_row, out_ch.out_col, out_ch.out_value);
          err_count++;
        end else begin
          want = result_elems.pop_front();
          if (out_ch.out_row !== want.row) begin
            $error("out_row: expected %0d, actual %0d", want.row, out_ch.out_row);
            err_count++;
          end
          if (out_ch.out_col !== want.col) begin
            $error("out_col: expected %0d, actual %0d", want.col, out_ch.out_col);
            err_count++;
          end
          if (out_ch.out_value !== want.value) begin
            $error("out_value: expected %h, actual %h", want.value, out_ch.out_value);
            err_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_ch.last);
            err_count++;
          end
          if (out_ch.dim_error !== want.err) begin
            $error("dim_error: expected %b, actual %b", want.err, out_ch.dim_error);
            err_count++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idling_on && $urandom_range(0, 7) == 0) sink_stall = $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[matrix_mul_add_sub_unit_top] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_A_ROWS:    a_rows_cfg = data;
      REG_A_COLS:    a_cols_cfg = data;
      REG_B_ROWS:    b_rows_cfg = data;
      REG_B_COLS:    b_cols_cfg = data;
      REG_OPERATION: op_cfg = data[OP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [DIM_W-1:0] ar, ac, br, bc,
                              input logic [OP_W-1:0] op);
    write_reg(REG_A_ROWS, ar);
    write_reg(REG_A_COLS, ac);
    write_reg(REG_B_ROWS, br);
    write_reg(REG_B_COLS, bc);
    write_reg(REG_OPERATION, {2'b00, op});
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Holds the sender until every pending result has transferred, then lets the unit settle.
  // The falling edge is used so that the driver's updates of this cycle are all visible.
  task automatic wait_drained();
    do @(negedge clk);
    while (item_q.size() != 0 || in_ch.valid || result_elems.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_item(input cmd_t cmd, input int r, input int c,
                           input logic [VAL_W-1:0] v);
    mat_item_t it;
    it.cmd   = cmd;
    it.row   = r[POS_W-1:0];
    it.col   = c[POS_W-1:0];
    it.value = v;
    item_q.push_back(it);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int signed near_one;
    near_one = int'($urandom_range(0, 20'hF_FFFF)) - 32'sh8_0000;
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      4: return '0;
      default: return near_one;
    endcase
  endfunction

  function automatic int pick_dim();
    if ($urandom_range(0, 9) == 0) return DIM_MAX;
    return $urandom_range(1, 4);
  endfunction

  // A dimension of 1 may be written as 0 and one of 8 as anything above; the unit clamps both.
  function automatic logic [DIM_W-1:0] enc_dim(int d);
    if (d == 1 && $urandom_range(0, 3) == 0) return '0;
    if (d == DIM_MAX && $urandom_range(0, 1) == 0) begin
      return DIM_W'($urandom_range(DIM_MAX + 1, 15));
    end
    return d[DIM_W-1:0];
  endfunction

  initial begin
    int n_random, ar, ac, br, bc, r, c, n_writes;
    logic [OP_W-1:0] op;
    bit to_b;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idling_on = 1'b1;
    a_rows_cfg = 4'd8;
    a_cols_cfg = 4'd8;
    b_rows_cfg = 4'd8;
    b_cols_cfg = 4'd8;
    op_cfg = OP_MUL;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full 8x8 multiply straight after reset: positive saturation and negative floor products.
    push_item(CMD_WR_A, 0, 0, 32'h7FFF_FFFF);
    push_item(CMD_WR_A, 0, 1, 32'h7FFF_FFFF);
    push_item(CMD_WR_B, 0, 0, 32'h7FFF_FFFF);
    push_item(CMD_WR_B, 1, 0, 32'h7FFF_FFFF);
    push_item(CMD_WR_A, 7, 7, 32'h8000_0000);
    push_item(CMD_WR_B, 7, 7, 32'h0000_FFFF);
    push_item(CMD_COMPUTE, 7, 7, 32'hFFFF_FFFF);
    wait_drained();

    // Indexes past the register list must be ignored.
    for (int i = REG_OPERATION + 1; i <= REG_LAST; i++) write_reg(i[CIDX_W-1:0], 4'hF);
    apply_config(4'd2, 4'd2, 4'd2, 4'd2, OP_ADD);
    push_item(CMD_WR_A, 1, 1, 32'h7FFF_FFFF);
    push_item(CMD_WR_B, 1, 1, 32'h0001_0000);
    push_item(CMD_COMPUTE, 0, 0, '0);
    wait_drained();

    apply_config(4'd2, 4'd2, 4'd2, 4'd2, OP_SUB);
    push_item(CMD_WR_A, 0, 0, 32'h8000_0000);
    push_item(CMD_WR_B, 0, 0, 32'h0000_0001);
    push_item(CMD_COMPUTE, 0, 0, '0);
    push_item(CMD_CLEAR, 0, 0, '0);
    push_item(CMD_COMPUTE, 0, 0, '0);
    wait_drained();

    // Multiply with mismatched inner dimensions.
    apply_config(4'd0, 4'd3, 4'd2, 4'd15, OP_MUL);
    push_item(CMD_COMPUTE, 0, 0, '0);
    wait_drained();

    // Add with unequal shapes.
    apply_config(4'd3, 4'd2, 4'd3, 4'd3, OP_ADD);
    push_item(CMD_COMPUTE, 0, 0, '0);
    wait_drained();

    apply_config(4'd1, 4'd1, 4'd1, 4'd1, OP_UNUSED);
    push_item(CMD_COMPUTE, 0, 0, '0);
    wait_drained();

    // Clamped registers: 15 rows acts as 8, 0 columns as 1.
    apply_config(4'd15, 4'd1, 4'd1, 4'd0, OP_MUL);
    push_item(CMD_WR_B, 0, 0, 32'hFFFF_0000);
    push_item(CMD_COMPUTE, 0, 0, '0);
    wait_drained();

    // Random phases: load the region in use, then compute. Every phase boundary
    // holds the sender until the unit has drained.
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      if (n_random > RANDOM_ITEMS * 7 / 8) idling_on = 1'b0;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: op = OP_MUL;
        10, 11, 12, 13: op = OP_ADD;
        14, 15, 16, 17: op = OP_SUB;
        default: op = OP_UNUSED;
      endcase
      ar = pick_dim();
      ac = pick_dim();
      if (op == OP_MUL) begin
        br = ac;
        bc = pick_dim();
      end else begin
        br = ar;
        bc = ac;
      end
      if ($urandom_range(0, 9) == 0) br = pick_dim();
      apply_config(enc_dim(ar), enc_dim(ac), enc_dim(br), enc_dim(bc), op);
      if ($urandom_range(0, 3) == 0) begin
        push_item(CMD_CLEAR, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
        n_random++;
      end
      repeat ($urandom_range(2, 5)) begin
        n_writes = $urandom_range(2, 12);
        repeat (n_writes) begin
          to_b = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 9) == 0) begin
            r = $urandom_range(0, DIM_MAX - 1);
            c = $urandom_range(0, DIM_MAX - 1);
          end else begin
            r = $urandom_range(0, (to_b ? br : ar) - 1);
            c = $urandom_range(0, (to_b ? bc : ac) - 1);
          end
          push_item(to_b ? CMD_WR_B : CMD_WR_A, r, c, pick_value());
          n_random++;
        end
        if ($urandom_range(0, 19) == 0) begin
          push_item(CMD_CLEAR, 0, 0, '0);
          n_random++;
        end
        push_item(CMD_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom());
        n_random++;
      end
      wait_drained();
    end

    if (err_count == 0) begin
      $display("[matrix_mul_add_sub_unit_top] OK");
    end else begin
      $display("[matrix_mul_add_sub_unit_top] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/mmas_pkg.sv
src/mmas_in_if.sv
src/mmas_out_if.sv
src/mmas_ctrl.sv
src/mmas_dp.sv
src/matrix_mul_add_sub_unit_top.sv
tb/tb_matrix_mul_add_sub_unit_top.sv
